// File: rtl/scf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring chain force package
// Shared widths and register indexes for the spring chain force block.
// ----------------------------------------------------------------------------
package scf_pkg;
  localparam int POS_W = 32;
  localparam int CFG_W = 32;
  localparam int PAR_W = 31;
  localparam int IDX_W = 10;
  localparam int CFG_IDX_W = 2;
  localparam int DEF_MAX_PARTICLES = 1024;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANCHOR_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REST = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_K = 2'd3;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic first_in_chain;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] target_index;
    logic signed [POS_W-1:0] force_x;
    logic signed [POS_W-1:0] force_y;
    logic last_of_run;
    logic degenerate;
    logic index_overflow;
  } out_item_t;

  // Start, busy and done of the serial spring unit.
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } unit_ctl_t;
endpackage

// File: rtl/scf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring chain force stream channel
// Valid/ready channel carrying one item of type T.
// ----------------------------------------------------------------------------
interface scf_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/scf_spring.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring chain force serial spring unit
// Computes the Hooke force for one separation bit-serially; it takes a new separation only when idle.
// ----------------------------------------------------------------------------
module scf_spring
  import scf_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [POS_W:0] dx,
  input  logic signed [POS_W:0] dy,
  input  logic [PAR_W-1:0] rest_length,
  input  logic [PAR_W-1:0] spring_k,
  output logic busy,
  output logic done,
  output logic [POS_W-1:0] fx,
  output logic [POS_W-1:0] fy,
  output logic deg
);
  // Phases: square sum, root, scaled magnitude, two quotients, two products.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_Q    = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_SAT  = 3'd6;
  localparam int SW = 2*POS_W + 2;   // 66 bit square sum
  localparam int RW = POS_W + 1;     // 33 bit root
  localparam int UW = POS_W + FRAC_BITS + 1;
  localparam int PW = 2*POS_W + FRAC_BITS + 8;

  logic [2:0] state;
  logic [6:0] cnt;
  logic [POS_W-1:0] ax, ay;
  logic sx, sy, fneg;
  logic [SW-1:0] sum;
  // Bit serial add-shift squares: one bit of multiplier per cycle.
  logic [SW-1:0] acc;
  // Digit by digit root: remainder and root, two sum bits a step.
  logic [SW-1:0] rrem;
  logic [RW-1:0] root;
  logic [PW-1:0] prod;
  logic [UW-1:0] nx, ny, ux, uy, rx, ry;
  logic [PW-1:0] qv;
  logic [PW-1:0] px, py;
  logic [SW+1:0] trial;
  logic [UW:0] tx, ty;

  assign busy = (state != S_IDLE);

  always_comb begin
    trial = {rrem[SW-3:0], sum[SW-1 -: 2]} - {root, 2'b01};
  end

  always_comb begin
    tx = {rx, nx[UW-1]} - {{(UW-RW){1'b0}}, root};
    ty = {ry, ny[UW-1]} - {{(UW-RW){1'b0}}, root};
  end

  function automatic logic [POS_W-1:0] sat(input logic neg, input logic [PW-1:0] p);
    logic [PW-1:0] v;
    begin
      v = p >> FRAC_BITS;
      if (!neg) sat = (v > PW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : v[POS_W-1:0];
      else sat = (v > PW'(33'h0_8000_0000)) ? 32'h8000_0000 : 32'(-v[POS_W-1:0]);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            sx <= dx[POS_W];
            sy <= dy[POS_W];
            ax <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
            ay <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
            acc <= '0;
            cnt <= '0;
            state <= S_SQR;
          end
        end
        S_SQR: begin
          // Square each magnitude by shifting in one bit per cycle, x then y.
          if (cnt == 7'(POS_W-1)) begin
            sum <= (acc << 1) + (ax[0] ? SW'(ax) : '0);
            acc <= '0;
            cnt <= cnt + 7'd1;
          end else if (cnt == 7'(2*POS_W-1)) begin
            sum <= sum + (acc << 1) + (ay[0] ? SW'(ay) : '0);
            rrem <= '0;
            root <= '0;
            cnt <= '0;
            state <= S_ROOT;
          end else if (cnt < 7'(POS_W)) begin
            acc <= (acc << 1) + (ax[POS_W-1-cnt[4:0]] ? SW'(ax) : '0);
            cnt <= cnt + 7'd1;
          end else begin
            acc <= (acc << 1) + (ay[POS_W-1-cnt[4:0]] ? SW'(ay) : '0);
            cnt <= cnt + 7'd1;
          end
        end
        S_ROOT: begin
          if (!trial[SW+1]) begin
            rrem <= trial[SW-1:0];
            root <= {root[RW-2:0], 1'b1};
          end else begin
            rrem <= {rrem[SW-3:0], sum[SW-1 -: 2]};
            root <= {root[RW-2:0], 1'b0};
          end
          sum <= sum << 2;
          if (cnt == 7'(RW-1)) begin
            cnt <= '0;
            state <= S_Q;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_Q: begin
          if (root == '0) begin
            fx <= '0;
            fy <= '0;
            deg <= 1'b1;
            done <= 1'b1;
            state <= S_IDLE;
          end else begin
            deg <= 1'b0;
            fneg <= ({1'b0, root} > {2'b0, rest_length});
            qv <= PW'(({1'b0, root} > {2'b0, rest_length}) ?
                      {1'b0, root} - {2'b0, rest_length} :
                      {2'b0, rest_length} - {1'b0, root});
            prod <= '0;
            cnt <= '0;
            state <= S_MUL;
            nx <= {ax, {FRAC_BITS{1'b0}}, 1'b0} >> 1;
            ny <= {ay, {FRAC_BITS{1'b0}}, 1'b0} >> 1;
          end
        end
        S_MUL: begin
          // q = k*|disp| >> FRAC, k shifted in one bit per cycle.
          prod <= (prod << 1) + (spring_k[PAR_W-1-cnt[4:0]] ? qv : '0);
          if (cnt == 7'(PAR_W-1)) begin
            qv <= ((prod << 1) + (spring_k[0] ? qv : '0)) >> FRAC_BITS;
            rx <= '0;
            ry <= '0;
            cnt <= '0;
            state <= S_DIV;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_DIV: begin
          // Restoring division of both magnitudes by the root, one bit a cycle.
          if (!tx[UW]) begin
            rx <= tx[UW-1:0];
            ux <= {ux[UW-2:0], 1'b1};
          end else begin
            rx <= {rx[UW-2:0], nx[UW-1]};
            ux <= {ux[UW-2:0], 1'b0};
          end
          if (!ty[UW]) begin
            ry <= ty[UW-1:0];
            uy <= {uy[UW-2:0], 1'b1};
          end else begin
            ry <= {ry[UW-2:0], ny[UW-1]};
            uy <= {uy[UW-2:0], 1'b0};
          end
          nx <= nx << 1;
          ny <= ny << 1;
          if (cnt == 7'(UW-1)) begin
            px <= '0;
            py <= '0;
            cnt <= '0;
            state <= S_SAT;
          end else begin
            cnt <= cnt + 7'd1;
          end
        end
        S_SAT: begin
          // Products q*ux and q*uy, one bit of the quotient per cycle.
          px <= (px << 1) + (ux[UW-1-cnt[5:0]] ? qv : '0);
          py <= (py << 1) + (uy[UW-1-cnt[5:0]] ? qv : '0);
          cnt <= cnt + 7'd1;
          if (cnt == 7'(UW-1)) begin
            fx <= sat(fneg != sx, (px << 1) + (ux[0] ? qv : '0));
            fy <= sat(fneg != sy, (py << 1) + (uy[0] ? qv : '0));
            done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("spring done while busy");
  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    (done && deg) |-> (fx == '0 && fy == '0)) else $error("degenerate force not zero");
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("spring did not start");
`endif
endmodule

// File: rtl/spring_chain_forces_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring chain force core
// Hooke spring forces along a particle chain, Q16.16, one item at a time.
// ----------------------------------------------------------------------------
// Each input item is one particle position. Particle zero is sprung to the
// anchor and gives one result; each later particle gives two results, its own
// force and then the opposite force on the previous particle. The forces are
// computed by one bit-serial spring unit in turn: squares, root, stiffness
// product, both quotients side by side and both products side by side. The
// core takes a new item only once the last result of the item before it is
// loaded into the output register. A zero separation skips the last three
// steps of the unit, and an item that arrives with the chain full gives a
// zero force without starting the unit. A result waits in an output register
// while the next item is taken in; a receiver that stalls while that register
// is still full holds the core in its output step and lengthens the item by
// the stall.
module spring_chain_forces_core
  import scf_pkg::*;
#(
  parameter int MAX_PARTICLES = DEF_MAX_PARTICLES,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic clk,
  input  logic rst,
  scf_if.sink   in_ch,
  scf_if.source out_ch,
  input  logic cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);
  localparam int CW = $clog2(MAX_PARTICLES + 1);
  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_OWN  = 2'd1;
  localparam logic [1:0] P_OPP  = 2'd2;
  localparam logic [1:0] P_PUT  = 2'd3;

  logic signed [POS_W-1:0] anchor_x, anchor_y, prev_x, prev_y, cur_x, cur_y;
  logic [PAR_W-1:0] rest_length, spring_k;
  logic [CW-1:0] next_index;
  logic [1:0] phase;
  logic two;
  logic opp;
  logic ovf;
  logic start;
  logic load;
  logic put_last;
  logic signed [POS_W:0] dx, dy;
  logic busy, done, deg;
  logic [POS_W-1:0] fx, fy;
  out_item_t held;
  logic held_valid;
  unit_ctl_t ctl;

  assign ctl = '{start: start, busy: busy, done: done};

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_x <= '0;
      anchor_y <= '0;
      rest_length <= '0;
      spring_k <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ANCHOR_X: anchor_x <= cfg_data;
        REG_ANCHOR_Y: anchor_y <= cfg_data;
        REG_REST: rest_length <= cfg_data[PAR_W-1:0];
        REG_K: spring_k <= cfg_data[PAR_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready = (phase == P_IDLE);
  assign out_ch.valid = held_valid;
  assign out_ch.data = held;

  // The output register takes a new result once it is empty or being emptied.
  assign load = (phase == P_PUT) && (!held_valid || out_ch.ready);
  assign put_last = ovf || !two || opp;

  scf_spring #(.FRAC_BITS(FRAC_BITS)) u_spring (
    .clk(clk), .rst(rst), .start(start), .dx(dx), .dy(dy),
    .rest_length(rest_length), .spring_k(spring_k),
    .busy(busy), .done(done), .fx(fx), .fy(fy), .deg(deg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (out_ch.ready) begin
      held_valid <= 1'b0;
    end
    if (load) begin
      held.target_index <= ovf ? IDX_W'(MAX_PARTICLES - 1) :
                           opp ? IDX_W'(next_index - CW'(1)) : IDX_W'(next_index);
      held.force_x <= ovf ? '0 : fx;
      held.force_y <= ovf ? '0 : fy;
      held.last_of_run <= put_last;
      held.degenerate <= !ovf && deg;
      held.index_overflow <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      start <= 1'b0;
      next_index <= '0;
      prev_x <= '0;
      prev_y <= '0;
    end else begin
      case (phase)
        P_IDLE: begin
          if (in_ch.valid) begin
            cur_x <= in_ch.data.pos_x;
            cur_y <= in_ch.data.pos_y;
            if (in_ch.data.first_in_chain || next_index == '0) begin
              dx <= {in_ch.data.pos_x[POS_W-1], in_ch.data.pos_x} -
                    {anchor_x[POS_W-1], anchor_x};
              dy <= {in_ch.data.pos_y[POS_W-1], in_ch.data.pos_y} -
                    {anchor_y[POS_W-1], anchor_y};
              two <= 1'b0;
              ovf <= 1'b0;
              next_index <= '0;
              start <= 1'b1;
              phase <= P_OWN;
            end else if (next_index == CW'(MAX_PARTICLES)) begin
              // Chain full: a single zero force, state left alone.
              ovf <= 1'b1;
              start <= 1'b0;
              phase <= P_PUT;
            end else begin
              dx <= {in_ch.data.pos_x[POS_W-1], in_ch.data.pos_x} -
                    {prev_x[POS_W-1], prev_x};
              dy <= {in_ch.data.pos_y[POS_W-1], in_ch.data.pos_y} -
                    {prev_y[POS_W-1], prev_y};
              two <= 1'b1;
              ovf <= 1'b0;
              start <= 1'b1;
              phase <= P_OWN;
            end
          end else begin
            start <= 1'b0;
          end
        end
        P_OWN, P_OPP: begin
          // The unit keeps its result until the output register is free.
          start <= 1'b0;
          if (done) begin
            opp <= (phase == P_OPP);
            phase <= P_PUT;
            if (two && phase == P_OWN) begin
              dx <= -dx;
              dy <= -dy;
            end
          end
        end
        P_PUT: begin
          if (load) begin
            if (put_last) begin
              start <= 1'b0;
              phase <= P_IDLE;
              if (!ovf) begin
                prev_x <= cur_x;
                prev_y <= cur_y;
                next_index <= next_index + CW'(1);
              end
            end else begin
              start <= 1'b1;
              phase <= P_OPP;
            end
          end else begin
            start <= 1'b0;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    next_index <= CW'(MAX_PARTICLES)) else $error("index past chain length");
  a_start_free: assert property (@(posedge clk) disable iff (rst)
    ctl.start |-> !ctl.busy) else $error("spring started while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (held_valid && !out_ch.ready) |=> held_valid) else $error("item dropped");
`endif
endmodule
